[hdl/assert_macros.svh]
// assertion macros shared by the running-mean rail voltage rtl
// expects clk and rst_n (synchronous, active low) in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[hdl/armrv_pkg.sv]
// shared types and constants for the running-mean rail voltage block
// no dependencies; used by armrv_ctrl, armrv_dp and the top level
`timescale 1ns / 1ps

package armrv_pkg;

  // default parameter values
  localparam int DEF_SAMPLE_COUNT        = 30;
  localparam int DEF_REF_MIN_COUNT       = 800;
  localparam int DEF_REF_MAX_COUNT       = 1900;
  localparam int DEF_BANDGAP_MIN_MV      = 1000;
  localparam int DEF_BANDGAP_MAX_MV      = 1400;
  localparam int DEF_BANDGAP_FALLBACK_MV = 1200;

  // field widths
  localparam int REF_W     = 16;
  localparam int SUP_W     = 16;
  localparam int TMP_W     = 9;
  localparam int SUM_W     = 16;
  localparam int CV_W      = 14;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam int IN_TDATA_W  = 48;  // 41 bits of fields, padded to bytes
  localparam int OUT_TDATA_W = 40;  // 39 bits of fields, padded to bytes
  localparam int OUT_TUSER_W = 1;

  // arithmetic constants
  localparam int TMP_MAX          = 511;
  localparam int SUPPLY_MAX_COUNT = 4095;
  localparam int VOLT_LIMIT       = 9990;
  localparam int BANDGAP_SCALE    = 40960;
  localparam int DIVISOR_RESET    = 20480;

  // internal widths
  localparam int SAMPLE_W = 12;                 // accepted ref and supply samples
  localparam int MEAN_W   = 12;                 // any rounded mean
  localparam int BG_W     = 11;                 // effective bandgap mV
  localparam int RAIL_W   = 26;                 // bandgap times scale, rail quotient
  localparam int CVN_W    = RAIL_W + MEAN_W + 1; // rail * supply mean + half divisor
  localparam int LIM_W    = CV_W + CFG_W;       // (limit + 1) * divisor
  localparam int CNT_W    = $clog2(RAIL_W + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BANDGAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 1'b1;

  // accumulator picked for the mean unit
  typedef enum logic [1:0] {
    MSEL_TMP = 2'd0,
    MSEL_REF = 2'd1,
    MSEL_SUP = 2'd2
  } mean_sel_t;

  typedef struct packed {
    logic      in_load;
    logic      prime;
    logic      upd_t;
    logic      upd_r;
    logic      upd_s;
    logic      mean_go;
    mean_sel_t mean_sel;
    logic      cap_ref;
    logic      cap_sup;
    logic      rail_load;
    logic      cv_load;
    logic      div_step;
    logic      prod_go;
    logic      held_sat;
    logic      held_q;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic primed;
    logic div_zero;
    logic div_last;
    logic cv_sat;
    logic out_free;
  } dp_sts_t;

endpackage

[hdl/armrv_ctrl.sv]
// sequencing state machine for the running-mean rail voltage block
// depends on armrv_pkg and assert_macros.svh; drives armrv_dp by command struct
`timescale 1ns / 1ps
`include "assert_macros.svh"

module armrv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  armrv_pkg::dp_sts_t sts,
  output armrv_pkg::dp_cmd_t cmd
);
  import armrv_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_CHECK    = 16'h0002,
    S_MOLD_T   = 16'h0004,
    S_MOLD_R   = 16'h0008,
    S_MOLD_S   = 16'h0010,
    S_UPD_S    = 16'h0020,
    S_MNEW_R   = 16'h0040,
    S_MNEW_S   = 16'h0080,
    S_RAIL_LD  = 16'h0100,
    S_RAIL_RUN = 16'h0200,
    S_PROD     = 16'h0400,
    S_SATCHK   = 16'h0800,
    S_CV_RUN   = 16'h1000,
    S_HOLD     = 16'h2000,
    S_TMEAN    = 16'h4000,
    S_DONE     = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.mean_sel = MSEL_TMP;
    case (state_r)
      S_IDLE: begin
        cmd.in_load = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.sample_ok) begin
          state_nxt = S_TMEAN;
        end else if (!sts.primed) begin
          cmd.prime = 1'b1;
          state_nxt = S_MNEW_R;
        end else begin
          state_nxt = S_MOLD_T;
        end
      end
      // means of the old accumulators, each folded in the state after its mean
      S_MOLD_T: begin
        cmd.mean_go  = 1'b1;
        cmd.mean_sel = MSEL_TMP;
        state_nxt    = S_MOLD_R;
      end
      S_MOLD_R: begin
        cmd.mean_go  = 1'b1;
        cmd.mean_sel = MSEL_REF;
        cmd.upd_t    = 1'b1;
        state_nxt    = S_MOLD_S;
      end
      S_MOLD_S: begin
        cmd.mean_go  = 1'b1;
        cmd.mean_sel = MSEL_SUP;
        cmd.upd_r    = 1'b1;
        state_nxt    = S_UPD_S;
      end
      S_UPD_S: begin
        cmd.upd_s = 1'b1;
        state_nxt = S_MNEW_R;
      end
      // means of the updated accumulators for the voltage
      S_MNEW_R: begin
        cmd.mean_go  = 1'b1;
        cmd.mean_sel = MSEL_REF;
        state_nxt    = S_MNEW_S;
      end
      S_MNEW_S: begin
        cmd.mean_go  = 1'b1;
        cmd.mean_sel = MSEL_SUP;
        cmd.cap_ref  = 1'b1;
        state_nxt    = S_RAIL_LD;
      end
      S_RAIL_LD: begin
        cmd.cap_sup = 1'b1;
        if (sts.div_zero) begin
          cmd.held_sat = 1'b1;
          state_nxt    = S_TMEAN;
        end else begin
          cmd.rail_load = 1'b1;
          state_nxt     = S_RAIL_RUN;
        end
      end
      S_RAIL_RUN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod_go = 1'b1;
        state_nxt   = S_SATCHK;
      end
      S_SATCHK: begin
        if (sts.cv_sat) begin
          cmd.held_sat = 1'b1;
          state_nxt    = S_TMEAN;
        end else begin
          cmd.cv_load = 1'b1;
          state_nxt   = S_CV_RUN;
        end
      end
      S_CV_RUN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        cmd.held_q = 1'b1;
        state_nxt  = S_TMEAN;
      end
      S_TMEAN: begin
        cmd.mean_go  = 1'b1;
        cmd.mean_sel = MSEL_TMP;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_NXT(a_accept_starts, in_tvalid && in_tready, state_r == S_CHECK, "transfer did not start check")
  `ASSERT_NXT(a_rail_to_prod, state_r == S_RAIL_RUN && sts.div_last, state_r == S_PROD, "rail divide did not end")
  `ASSERT_CLK(a_no_div_while_idle, (state_r == S_IDLE) |-> !cmd.div_step && !cmd.out_load, "datapath busy while idle")

endmodule

[hdl/armrv_dp.sv]
// datapath: input and config registers, accumulators, mean unit, shared divider
// depends on armrv_pkg and assert_macros.svh; controlled by armrv_ctrl
`timescale 1ns / 1ps
`include "assert_macros.svh"

module armrv_dp #(
  parameter int SAMPLE_COUNT        = armrv_pkg::DEF_SAMPLE_COUNT,
  parameter int REF_MIN_COUNT       = armrv_pkg::DEF_REF_MIN_COUNT,
  parameter int REF_MAX_COUNT       = armrv_pkg::DEF_REF_MAX_COUNT,
  parameter int BANDGAP_MIN_MV      = armrv_pkg::DEF_BANDGAP_MIN_MV,
  parameter int BANDGAP_MAX_MV      = armrv_pkg::DEF_BANDGAP_MAX_MV,
  parameter int BANDGAP_FALLBACK_MV = armrv_pkg::DEF_BANDGAP_FALLBACK_MV
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  armrv_pkg::dp_cmd_t                  cmd,
  output armrv_pkg::dp_sts_t                  sts,
  input  logic [armrv_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                cfg_wr,
  input  logic [armrv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [armrv_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [armrv_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [armrv_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import armrv_pkg::*;

  localparam int TACC_W = $clog2(TMP_MAX * SAMPLE_COUNT + 1);
  localparam int SACC_W = $clog2(SUPPLY_MAX_COUNT * SAMPLE_COUNT + 1);
  localparam int MX_W   = $clog2(SUPPLY_MAX_COUNT * SAMPLE_COUNT + SAMPLE_COUNT / 2 + 1);
  localparam int MSH    = MX_W + $clog2(SAMPLE_COUNT);
  localparam int MP_W   = 2 * MX_W + 1;
  // reciprocal rounded up: exact floor division for every mean input
  localparam longint unsigned MUL_L =
    ((64'd1 << MSH) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);
  localparam logic [MX_W:0]   MEAN_MUL  = (MX_W + 1)'(MUL_L);
  localparam logic [MX_W-1:0] MEAN_HALF = MX_W'(SAMPLE_COUNT / 2);

  // input item
  logic [REF_W-1:0] rc_r;
  logic [SUP_W-1:0] sc_r;
  logic [TMP_W-1:0] tc_r;
  logic             sample_ok;

  // configuration
  logic [CFG_W-1:0] bg_r, bg_nxt;
  logic [CFG_W-1:0] div_r, div_nxt;

  // accumulators
  logic [TACC_W-1:0] tacc_r, tacc_nxt;
  logic [SACC_W-1:0] racc_r, racc_nxt;
  logic [SACC_W-1:0] sacc_r, sacc_nxt;
  logic              primed_r, primed_nxt;

  // mean unit
  logic [MX_W-1:0]   mean_acc;
  logic [MX_W-1:0]   mean_x;
  logic [MP_W-1:0]   mean_prod;
  logic [MEAN_W-1:0] mean_r;
  logic [MEAN_W-1:0] ref_mean_r;
  logic [MEAN_W-1:0] sup_mean_r;

  // voltage path
  logic [BG_W-1:0]   bg_eff;
  logic [RAIL_W-1:0] rail_num;
  logic [CVN_W-1:0]  rem_r;
  logic [CVN_W-1:0]  dsh_r;
  logic [RAIL_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rem_ge;
  logic [CVN_W-2:0]  cv_prod;
  logic [CVN_W-1:0]  cvn_r;
  logic [LIM_W-1:0]  lim_r;
  logic [CV_W-1:0]   held_r, held_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_acc_r;
  logic [TMP_W-1:0]  out_tmean_r;
  logic [SUM_W-1:0]  out_tsum_r;
  logic [CV_W-1:0]   out_volt_r;

  // sample window check
  assign sample_ok = !(rc_r < REF_W'(REF_MIN_COUNT) || rc_r > REF_W'(REF_MAX_COUNT) ||
                       sc_r > SUP_W'(SUPPLY_MAX_COUNT));

  // rounded mean: (acc + n/2) / n by reciprocal multiply
  always_comb begin
    case (cmd.mean_sel)
      MSEL_TMP: mean_acc = MX_W'(tacc_r);
      MSEL_REF: mean_acc = MX_W'(racc_r);
      MSEL_SUP: mean_acc = MX_W'(sacc_r);
      default:  mean_acc = '0;
    endcase
  end
  assign mean_x    = mean_acc + MEAN_HALF;
  assign mean_prod = MP_W'(mean_x) * MP_W'(MEAN_MUL);

  // accumulator updates
  always_comb begin
    tacc_nxt   = tacc_r;
    racc_nxt   = racc_r;
    sacc_nxt   = sacc_r;
    primed_nxt = primed_r;
    if (cmd.prime) begin
      tacc_nxt   = TACC_W'(TACC_W'(tc_r) * TACC_W'(SAMPLE_COUNT));
      racc_nxt   = SACC_W'(SACC_W'(rc_r[SAMPLE_W-1:0]) * SACC_W'(SAMPLE_COUNT));
      sacc_nxt   = SACC_W'(SACC_W'(sc_r[SAMPLE_W-1:0]) * SACC_W'(SAMPLE_COUNT));
      primed_nxt = 1'b1;
    end
    if (cmd.upd_t) begin
      tacc_nxt = tacc_r - TACC_W'(mean_r) + TACC_W'(tc_r);
    end
    if (cmd.upd_r) begin
      racc_nxt = racc_r - SACC_W'(mean_r) + SACC_W'(rc_r[SAMPLE_W-1:0]);
    end
    if (cmd.upd_s) begin
      sacc_nxt = sacc_r - SACC_W'(mean_r) + SACC_W'(sc_r[SAMPLE_W-1:0]);
    end
  end

  // configuration writes
  always_comb begin
    bg_nxt  = bg_r;
    div_nxt = div_r;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_BANDGAP: bg_nxt  = cfg_data;
        CFG_DIVISOR: div_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // bandgap scale numerator
  always_comb begin
    if (bg_r < CFG_W'(BANDGAP_MIN_MV) || bg_r > CFG_W'(BANDGAP_MAX_MV)) begin
      bg_eff = BG_W'(BANDGAP_FALLBACK_MV);
    end else begin
      bg_eff = bg_r[BG_W-1:0];
    end
  end
  assign rail_num = RAIL_W'(RAIL_W'(bg_eff) * RAIL_W'(BANDGAP_SCALE))
                  + RAIL_W'(ref_mean_r >> 1);

  assign rem_ge  = (rem_r >= dsh_r);
  assign cv_prod = (CVN_W - 1)'((CVN_W - 1)'(q_r) * (CVN_W - 1)'(sup_mean_r));

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.rail_load) begin
      cnt_nxt = CNT_W'(RAIL_W);
    end else if (cmd.cv_load) begin
      cnt_nxt = CNT_W'(CV_W);
    end else if (cmd.div_step) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    held_nxt = held_r;
    if (cmd.held_sat) begin
      held_nxt = CV_W'(VOLT_LIMIT);
    end else if (cmd.held_q) begin
      held_nxt = q_r[CV_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r        <= '0;
      div_r       <= CFG_W'(DIVISOR_RESET);
      tacc_r      <= '0;
      racc_r      <= '0;
      sacc_r      <= '0;
      primed_r    <= 1'b0;
      held_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bg_r        <= bg_nxt;
      div_r       <= div_nxt;
      tacc_r      <= tacc_nxt;
      racc_r      <= racc_nxt;
      sacc_r      <= sacc_nxt;
      primed_r    <= primed_nxt;
      held_r      <= held_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      rc_r <= in_tdata[REF_W-1:0];
      sc_r <= in_tdata[REF_W+SUP_W-1:REF_W];
      tc_r <= in_tdata[REF_W+SUP_W+TMP_W-1:REF_W+SUP_W];
    end
    if (cmd.mean_go) begin
      mean_r <= MEAN_W'(mean_prod >> MSH);
    end
    if (cmd.cap_ref) begin
      ref_mean_r <= mean_r;
    end
    if (cmd.cap_sup) begin
      sup_mean_r <= mean_r;
    end
    if (cmd.rail_load) begin
      rem_r <= CVN_W'(rail_num);
      dsh_r <= CVN_W'(ref_mean_r) << (RAIL_W - 1);
      q_r   <= '0;
    end else if (cmd.cv_load) begin
      rem_r <= cvn_r;
      dsh_r <= CVN_W'(div_r) << (CV_W - 1);
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[RAIL_W-2:0], rem_ge};
    end
    if (cmd.prod_go) begin
      cvn_r <= CVN_W'(cv_prod) + CVN_W'(div_r >> 1);
      lim_r <= LIM_W'(div_r) * LIM_W'(VOLT_LIMIT + 1);
    end
    if (cmd.out_load) begin
      out_acc_r   <= sample_ok;
      out_tmean_r <= mean_r[TMP_W-1:0];
      out_tsum_r  <= SUM_W'(tacc_r);
      out_volt_r  <= held_r;
    end
  end

  assign sts.sample_ok = sample_ok;
  assign sts.primed    = primed_r;
  assign sts.div_zero  = (ref_mean_r == '0) || (div_r == '0);
  assign sts.div_last  = (cnt_r == CNT_W'(1));
  assign sts.cv_sat    = (cvn_r >= CVN_W'(lim_r));
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_volt_r, out_tsum_r, out_tmean_r};
  assign out_tuser  = out_acc_r;

  `ASSERT_CLK(a_fold_after_prime, (cmd.upd_t || cmd.upd_r || cmd.upd_s) |-> (primed_r && sample_ok), "fold on rejected or unprimed item")
  `ASSERT_CLK(a_prime_once, cmd.prime |-> (!primed_r && sample_ok), "prime repeated or on rejected item")
  `ASSERT_CLK(a_held_range, held_r <= CV_W'(VOLT_LIMIT), "held voltage above limit")
  `ASSERT_CLK(a_good_result_primed, (out_valid_r && out_acc_r) |-> primed_r, "accepted result before priming")

endmodule

[hdl/adc_running_mean_rail_voltage_top.sv]
// top level of the running-mean rail voltage block
// depends on armrv_pkg, armrv_ctrl and armrv_dp
`timescale 1ns / 1ps

// usage:
//   in_* stream: one transfer per set of readings (reference count, supply
//   count, temperature in degrees). out_* stream: exactly one result per input
//   transfer, in order. cfg_* port: register writes, always ready; write only
//   while no item is in flight (bandgap mV at index 0, supply divisor at index 1).
// item flow:
//   a rejected item (out-of-window reading) goes from the check straight to the
//   temperature mean and the output register; an accepted item folds its
//   readings into the accumulators (the priming item loads them), takes the
//   reference and supply means, then runs the shared shift-subtract divider:
//   26 steps for the rail quotient and 14 for the centivolt quotient, cut short
//   when the voltage saturates. one item is in flight at a time.
// reset:
//   synchronous, active low; clears the accumulators, the primed flag and the
//   held voltage, sets bandgap to 0 (fallback applies) and divisor to 20480.
// stalls:
//   a finished result waits in the output register while the next item is
//   already accepted and worked on; the controller holds only if a second
//   result is ready before the first one has been taken.

module adc_running_mean_rail_voltage_top #(
  parameter int SAMPLE_COUNT        = armrv_pkg::DEF_SAMPLE_COUNT,
  parameter int REF_MIN_COUNT       = armrv_pkg::DEF_REF_MIN_COUNT,
  parameter int REF_MAX_COUNT       = armrv_pkg::DEF_REF_MAX_COUNT,
  parameter int BANDGAP_MIN_MV      = armrv_pkg::DEF_BANDGAP_MIN_MV,
  parameter int BANDGAP_MAX_MV      = armrv_pkg::DEF_BANDGAP_MAX_MV,
  parameter int BANDGAP_FALLBACK_MV = armrv_pkg::DEF_BANDGAP_FALLBACK_MV
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] reference_count, [31:16] supply_count,
  // [40:32] temperature_degrees, [47:41] zero
  input  logic [armrv_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [8:0] temperature_mean, [24:9] temperature_sum_low,
  // [38:25] supply_cv, [39] zero
  output logic [armrv_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] accepted
  output logic [armrv_pkg::OUT_TUSER_W-1:0] out_tuser,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [armrv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [armrv_pkg::CFG_W-1:0]       cfg_data
);
  import armrv_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // state machine: accepts a transfer, then walks fold, mean and divide steps
  armrv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: accumulators, reciprocal mean unit, divider, output register
  armrv_dp #(
    .SAMPLE_COUNT        (SAMPLE_COUNT),
    .REF_MIN_COUNT       (REF_MIN_COUNT),
    .REF_MAX_COUNT       (REF_MAX_COUNT),
    .BANDGAP_MIN_MV      (BANDGAP_MIN_MV),
    .BANDGAP_MAX_MV      (BANDGAP_MAX_MV),
    .BANDGAP_FALLBACK_MV (BANDGAP_FALLBACK_MV)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
